// ===== rtl/etns_pkg.sv =====
// Shared types, operation codes and defaults for the nearest-select entry table.
`default_nettype none
package etns_pkg;

    localparam int DEPTH_DEF = 32;
    localparam logic [30:0] RIGHT_LIMIT_RST = 31'd139264;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_POP     = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_REVIVE  = 3'd4,
        OP_NEAREST = 3'd5,
        OP_RIGHT   = 3'd6,
        OP_READ    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

    typedef struct packed {
        logic signed [31:0] pos;
        logic               act;
        logic               alv;
        logic [15:0]        tag;
    } t_entry;

endpackage
`default_nettype wire

// ===== rtl/etns_mem.sv =====
// Entry store: one write port and one registered read port.
`default_nettype none
module etns_mem
    import etns_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/entry_table_nearest_select.sv =====
// Top level of the ordered entry table with nearest and right-most selection.
// Each operation goes from idle through the scan state to the finish state; a scan reads
// the entries it walks (up to DEPTH), while append, clear, error cases and empty tables walk none.
// Only one operation is in flight; the next transfer is taken in the cycle after
// the result is registered, while that result may still wait for the receiver.
// Reset (i_rst_n low, synchronous) empties the table and restores right_limit to 139264.
`default_nettype none
module entry_table_nearest_select
    import etns_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata,     // right_limit
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // slot_index[4:0], new_position[36:5], new_active[37], new_alive[38],
    // new_tag[54:39], reference_position[86:55], zero pad[87]
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,    // op[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // hit_index[4:0], hit_position[36:5], hit_tag[52:37], entry_count[58:53], pad
    output logic [63:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser     // found[0], error[2:1]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_fill;
    logic [30:0]        r_limit;
    t_op                r_op;
    t_err               r_err;
    logic signed [31:0] r_ref;
    t_entry             r_new;
    logic [CW-1:0]      r_rd, r_end, r_base, r_da;
    logic               r_dv;
    logic               r_any;
    logic [32:0]        r_min_d, r_last_d;
    logic [AW-1:0]      r_min_i, r_last_i;
    t_entry             r_min_e, r_last_e;
    logic signed [31:0] r_bp;

    logic               r_ov;
    logic               r_o_found;
    t_err               r_o_err;
    logic [4:0]         r_o_idx;
    logic [31:0]        r_o_pos;
    logic [15:0]        r_o_tag;
    logic [5:0]         r_o_cnt;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;

    logic               in_xfer, out_free, rd_go, slot_ok, fin_go;
    logic [4:0]         in_slot;
    t_op                in_op;
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic               near_last;

    etns_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (AW'(r_rd)),
        .o_rdata (mem_rdata)
    );

    assign in_op         = t_op'(s_axis_tuser);
    assign in_slot       = s_axis_tdata[4:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign fin_go        = (r_state == S_FIN) && out_free;
    assign rd_go         = (r_state == S_SCAN) && (r_rd < r_end);
    assign slot_ok       = (32'(in_slot) < 32'(r_fill));

    assign diff      = $signed({mem_rdata.pos[31], mem_rdata.pos})
                     - $signed({r_ref[31], r_ref});
    assign abs_diff  = diff[32] ? 33'(-diff) : 33'(diff);
    assign near_last = (r_last_d == r_min_d);

    // memory writes: shifts and revives during the scan, single writes at the end
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(r_da);
        mem_wdata = mem_rdata;
        if (r_state == S_SCAN && r_dv) begin
            unique case (r_op)
                OP_REVIVE: begin
                    mem_we        = 1'b1;
                    mem_wdata.alv = 1'b1;
                end
                OP_POP, OP_REMOVE: begin
                    mem_we    = (r_da != r_base);
                    mem_waddr = AW'(r_da - CW'(1));
                end
                default: mem_we = 1'b0;
            endcase
        end else if (fin_go) begin
            unique case (r_op)
                OP_APPEND: begin
                    mem_we    = (r_err == ERR_NONE);
                    mem_waddr = AW'(r_fill);
                    mem_wdata = r_new;
                end
                OP_NEAREST: begin
                    mem_we        = r_any;
                    mem_waddr     = near_last ? r_last_i : r_min_i;
                    mem_wdata     = near_last ? r_last_e : r_min_e;
                    mem_wdata.alv = 1'b0;
                end
                default: mem_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_limit <= RIGHT_LIMIT_RST;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op    <= in_op;
                        r_ref   <= s_axis_tdata[86:55];
                        r_new   <= '{pos: s_axis_tdata[36:5], act: s_axis_tdata[37],
                                     alv: s_axis_tdata[38], tag: s_axis_tdata[54:39]};
                        r_any   <= 1'b0;
                        r_bp    <= '0;
                        r_dv    <= 1'b0;
                        r_err   <= ERR_NONE;
                        r_base  <= '0;
                        r_rd    <= '0;
                        r_end   <= '0;
                        r_state <= S_SCAN;
                        unique case (in_op)
                            OP_APPEND: begin
                                if (32'(r_fill) >= DEPTH) begin
                                    r_err <= ERR_FULL;
                                end
                            end
                            OP_REMOVE, OP_READ: begin
                                if (slot_ok) begin
                                    r_base <= CW'(in_slot);
                                    r_rd   <= CW'(in_slot);
                                    r_end  <= (in_op == OP_READ) ?
                                              CW'(in_slot) + CW'(1) : r_fill;
                                end else begin
                                    r_err <= ERR_RANGE;
                                end
                            end
                            OP_CLEAR: r_end <= '0;
                            default:  r_end <= r_fill;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dv <= rd_go;
                    r_da <= r_rd;
                    if (rd_go) begin
                        r_rd <= r_rd + CW'(1);
                    end
                    if (r_dv) begin
                        unique case (r_op)
                            OP_POP, OP_REMOVE, OP_READ: begin
                                if (r_da == r_base) begin
                                    r_min_e <= mem_rdata;
                                    r_min_i <= AW'(r_da);
                                end
                            end
                            OP_NEAREST: begin
                                if (mem_rdata.act && mem_rdata.alv) begin
                                    r_any    <= 1'b1;
                                    r_last_d <= abs_diff;
                                    r_last_i <= AW'(r_da);
                                    r_last_e <= mem_rdata;
                                    if (!r_any || abs_diff < r_min_d) begin
                                        r_min_d <= abs_diff;
                                        r_min_i <= AW'(r_da);
                                        r_min_e <= mem_rdata;
                                    end
                                end
                            end
                            OP_RIGHT: begin
                                // later entries win ties; bound starts at zero
                                if (mem_rdata.act && mem_rdata.pos >= r_bp &&
                                    $signed({mem_rdata.pos[31], mem_rdata.pos})
                                        < $signed({2'b00, r_limit})) begin
                                    r_any   <= 1'b1;
                                    r_bp    <= mem_rdata.pos;
                                    r_min_i <= AW'(r_da);
                                    r_min_e <= mem_rdata;
                                end
                            end
                            default: r_any <= r_any;
                        endcase
                    end
                    if (!rd_go && !r_dv) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ov      <= 1'b1;
                        r_state   <= S_IDLE;
                        r_o_found <= 1'b0;
                        r_o_err   <= r_err;
                        r_o_idx   <= '0;
                        r_o_pos   <= '0;
                        r_o_tag   <= '0;
                        r_o_cnt   <= 6'(r_fill);
                        unique case (r_op)
                            OP_APPEND: begin
                                if (r_err == ERR_NONE) begin
                                    r_o_found <= 1'b1;
                                    r_fill    <= r_fill + CW'(1);
                                    r_o_cnt   <= 6'(r_fill + CW'(1));
                                end
                            end
                            OP_POP: begin
                                if (r_fill != '0) begin
                                    r_o_found <= 1'b1;
                                    r_o_pos   <= r_min_e.pos;
                                    r_o_tag   <= r_min_e.tag;
                                    r_fill    <= r_fill - CW'(1);
                                    r_o_cnt   <= 6'(r_fill - CW'(1));
                                end
                            end
                            OP_REMOVE: begin
                                if (r_err == ERR_NONE) begin
                                    r_o_found <= 1'b1;
                                    r_fill    <= r_fill - CW'(1);
                                    r_o_cnt   <= 6'(r_fill - CW'(1));
                                end
                            end
                            OP_CLEAR: begin
                                r_o_found <= 1'b1;
                                r_fill    <= '0;
                                r_o_cnt   <= '0;
                            end
                            OP_REVIVE: r_o_found <= 1'b1;
                            OP_NEAREST: begin
                                if (r_any) begin
                                    r_o_found <= 1'b1;
                                    r_o_idx   <= 5'(near_last ? r_last_i : r_min_i);
                                    r_o_pos   <= near_last ? r_last_e.pos : r_min_e.pos;
                                    r_o_tag   <= near_last ? r_last_e.tag : r_min_e.tag;
                                end
                            end
                            default: begin
                                // pick right and read share the captured entry
                                if ((r_op == OP_RIGHT) ? r_any : (r_err == ERR_NONE)) begin
                                    r_o_found <= 1'b1;
                                    r_o_idx   <= 5'(r_min_i);
                                    r_o_pos   <= r_min_e.pos;
                                    r_o_tag   <= r_min_e.tag;
                                end
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_o_cnt, r_o_tag, r_o_pos, r_o_idx};
    assign m_axis_tuser  = {r_o_err, r_o_found};

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= DEPTH)
        else $error("fill count beyond depth");

    a_result_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> m_axis_tvalid)
        else $error("finished operation gave no result");

    a_no_read_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_go |-> 32'(r_rd) < DEPTH)
        else $error("read beyond table");

    a_scan_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && mem_we) |-> 32'(mem_waddr) < 32'(r_fill))
        else $error("scan write outside stored entries");

endmodule
`default_nettype wire

// ===== tb/sv/entry_table_nearest_select_chk.sv =====
// Checker for the entry table: watches both streams, predicts each result and compares.
module entry_table_nearest_select_chk
    import etns_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [87:0] i_in_data,
    input  wire logic [2:0]  i_in_op,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_out_data,
    input  wire logic [2:0]  i_out_flags,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic               found;
        logic [1:0]         err;
        logic [4:0]         idx;
        logic signed [31:0] pos;
        logic [15:0]        tag;
        logic [5:0]         cnt;
    } t_result;

    t_entry      table_q[$];
    logic [30:0] right_limit;
    t_result     expected_results[$];

    function automatic logic [32:0] abs_dist(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d < 0 ? 33'(-d) : 33'(d);
    endfunction

    task automatic apply_op(input logic [2:0] op, input logic [87:0] d);
        t_result     r;
        t_entry      e;
        logic [4:0]  slot;
        logic signed [31:0] refp;
        logic [32:0] bd;
        int          best;
        int          last;
        slot = d[4:0];
        refp = d[86:55];
        r = '0;
        best = -1;
        last = -1;
        case (t_op'(op))
            OP_APPEND: begin
                if (table_q.size() >= DEPTH_DEF) r.err = ERR_FULL;
                else begin
                    e.pos = d[36:5]; e.act = d[37]; e.alv = d[38]; e.tag = d[54:39];
                    table_q = {table_q, e};
                    r.found = 1;
                end
            end
            OP_POP: begin
                if (table_q.size() > 0) begin
                    e = table_q[0];
                    table_q.delete(0);
                    r.found = 1; r.pos = e.pos; r.tag = e.tag;
                end
            end
            OP_REMOVE: begin
                if (slot >= table_q.size()) r.err = ERR_RANGE;
                else begin
                    table_q.delete(slot);
                    r.found = 1;
                end
            end
            OP_CLEAR: begin
                table_q.delete();
                r.found = 1;
            end
            OP_REVIVE: begin
                foreach (table_q[i]) table_q[i].alv = 1;
                r.found = 1;
            end
            OP_NEAREST: begin
                // the last eligible entry seeds the minimum; only strictly smaller beats it
                foreach (table_q[i]) if (table_q[i].act && table_q[i].alv) last = i;
                if (last >= 0) begin
                    best = last;
                    bd = abs_dist(table_q[last].pos, refp);
                    foreach (table_q[i])
                        if (table_q[i].act && table_q[i].alv &&
                            abs_dist(table_q[i].pos, refp) < bd) begin
                            bd = abs_dist(table_q[i].pos, refp);
                            best = i;
                        end
                    table_q[best].alv = 0;
                end
            end
            OP_RIGHT: begin
                foreach (table_q[i])
                    if (table_q[i].act && !table_q[i].pos[31] &&
                        table_q[i].pos[30:0] < right_limit &&
                        (best < 0 || table_q[i].pos >= table_q[best].pos))
                        best = i;
            end
            default: begin
                if (slot >= table_q.size()) r.err = ERR_RANGE;
                else best = slot;
            end
        endcase
        if (best >= 0) begin
            r.found = 1; r.idx = best[4:0];
            r.pos = table_q[best].pos; r.tag = table_q[best].tag;
        end
        r.cnt = 6'(table_q.size());
        expected_results = {expected_results, r};
    endtask

    always @(posedge i_clk) begin
        t_result act;
        t_result exp_r;
        if (!i_rst_n) begin
            table_q.delete();
            right_limit <= RIGHT_LIMIT_RST;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) right_limit <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) apply_op(i_in_op, i_in_data);
            if (i_out_valid && i_out_ready) begin
                act.found = i_out_flags[0]; act.err = i_out_flags[2:1];
                act.idx = i_out_data[4:0]; act.pos = i_out_data[36:5];
                act.tag = i_out_data[52:37]; act.cnt = i_out_data[58:53];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, act);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (act !== exp_r) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_r, act);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/sv/entry_table_nearest_select_tb.sv =====
// Testbench top: clock, reset, stimulus for the entry table and the verdict.
module entry_table_nearest_select_tb;
    import etns_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [30:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          hold_off = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    entry_table_nearest_select dut (.*);

    entry_table_nearest_select_chk chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_op(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_flags(m_axis_tuser),
        .o_errors(fail_count), .o_pending(pending)
    );

    // small position pools make ties and near misses common
    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_fffc + $urandom_range(0, 3);
            3: return $urandom_range(0, 140000);
            default: return $urandom_range(0, 12) * 1000 - 4000;
        endcase
    endfunction

    // hold the offer until it is taken; the caller drops valid when it stops sending
    task automatic send(input t_op op, input logic [4:0] slot, input logic [31:0] p,
                        input logic act, input logic alv, input logic [15:0] tag,
                        input logic [31:0] refp, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, refp, tag, alv, act, p, slot};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input bit gaps);
        int   k;
        t_op  op;
        k = $urandom_range(0, 99);
        if (k < 35) op = OP_APPEND;
        else if (k < 55) op = OP_NEAREST;
        else if (k < 65) op = OP_RIGHT;
        else if (k < 73) op = OP_READ;
        else if (k < 80) op = OP_POP;
        else if (k < 88) op = OP_REMOVE;
        else if (k < 94) op = OP_REVIVE;
        else if (k < 97) op = OP_CLEAR;
        else op = t_op'($urandom_range(0, 7));
        send(op, 5'($urandom()), pick_pos(), $urandom_range(0, 3) != 0, 1'($urandom()),
             16'($urandom()), pick_pos(), gaps);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [30:0] v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        int wait_n;
        if (i_rst_n) begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                if (wait_n != 0) begin
                    m_axis_tready <= 0;
                    repeat (wait_n) @(posedge i_clk);
                end
                m_axis_tready <= 1;
                do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] edge_pos [6] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff,
                                      32'd139263, 32'd139264};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // empty-table cases
        send(OP_POP, 0, 0, 0, 0, 0, 0, 0);
        send(OP_NEAREST, 0, 0, 0, 0, 0, 0, 0);
        send(OP_RIGHT, 0, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 31, 0, 0, 0, 0, 0, 0);
        send(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
        foreach (edge_pos[i])
            send(OP_APPEND, 0, edge_pos[i], 1, 1, 16'(16'hffff - i), 0, 0);
        send(OP_APPEND, 0, 32'd139263, 1, 1, 16'h0, 0, 0);
        send(OP_APPEND, 0, 5, 0, 1, 16'h1, 0, 0);
        send(OP_RIGHT, 0, 0, 0, 0, 0, 0, 0);
        send(OP_NEAREST, 0, 0, 0, 0, 0, 32'h8000_0000, 0);
        send(OP_NEAREST, 0, 0, 0, 0, 0, 32'h7fff_ffff, 0);
        send(OP_NEAREST, 0, 0, 0, 0, 0, 32'd139263, 0);
        send(OP_READ, 2, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 8, 0, 0, 0, 0, 0, 0);
        send(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0);
        send(OP_REVIVE, 0, 0, 0, 0, 0, 0, 0);
        send(OP_POP, 0, 0, 0, 0, 0, 0, 0);
        repeat (30) send(OP_APPEND, 0, pick_pos(), 1, 1, 16'($urandom()), 0, 0);
        send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        drain();
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        repeat (20) send_random(0);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_limit(31'd0);
                1: write_limit(31'h7fff_ffff);
                2: write_limit(31'd6000);
                3: write_limit(31'd1);
                default: write_limit(31'($urandom()));
            endcase
            repeat (400) send_random($urandom_range(0, 4) != 0);
            drain();
        end
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
